>>> design/assert_macros.svh
// assertion macros used by the sequencer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define AFS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sequencer assertion failed");

// next-cycle implication, disabled while reset is low
`define AFS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sequencer assertion failed");

`endif

>>> design/afs_pkg.sv
// types, codes and defaults of the animation frame sequencer
`default_nettype none
package afs_pkg;

	localparam int FRAME_WIDTH_DEF = 16;

	// play modes
	localparam logic [2:0] MODE_STOP     = 3'd0;
	localparam logic [2:0] MODE_CLAMP    = 3'd1;
	localparam logic [2:0] MODE_WRAP     = 3'd2;
	localparam logic [2:0] MODE_PINGPONG = 3'd3;
	localparam logic [2:0] MODE_JUMP     = 3'd4;

	// request types
	localparam logic REQ_STEP = 1'b0;
	localparam logic REQ_SET  = 1'b1;

	// register indexes
	localparam logic [2:0] REG_PLAY_MODE      = 3'd0;
	localparam logic [2:0] REG_LAST_FRAME     = 3'd1;
	localparam logic [2:0] REG_FRAME_STEP     = 3'd2;
	localparam logic [2:0] REG_JUMP_FRAME     = 3'd3;
	localparam logic [2:0] REG_OWN_KIND       = 3'd4;
	localparam logic [2:0] REG_QUEUED_KIND    = 3'd5;
	localparam logic [2:0] REG_QUEUED_TRIGGER = 3'd6;
	localparam logic [2:0] REG_QUEUED_START   = 3'd7;

	localparam logic signed [10:0] KIND_NONE  = -11'sd1;
	localparam logic signed [16:0] FRAME_NONE = -17'sd1;

	typedef struct packed {
		logic [2:0]         play_mode;
		logic [15:0]        last_frame;
		logic signed [15:0] frame_step;
		logic [15:0]        jump_frame;
		logic signed [10:0] own_kind;
		logic signed [10:0] queued_kind;
		logic signed [16:0] queued_trigger;
		logic signed [16:0] queued_start;
	} cfg_t;

	// lowest bits first: req_type, new_frame, new_first, peek
	typedef struct packed {
		logic        peek;
		logic        new_first;
		logic [15:0] new_frame;
		logic        req_type;
	} req_t;

	// lowest bits first: motion_kind, frame_out, range_error
	typedef struct packed {
		logic               range_error;
		logic signed [16:0] frame_out;
		logic signed [10:0] motion_kind;
	} result_t;

	typedef struct packed {
		logic first_pending;
		logic step_backward;
	} flags_t;

endpackage
`default_nettype wire

>>> design/animation_frame_sequencer.sv
// top level of the animation frame sequencer
// an input beat reaches its result beat through the input register and then the result register
// throughput: one request per cycle, results stream back to back while m_axis_tready holds
// with m_axis_tready low the block holds two requests, then s_axis_tready drops until a take
// reset (arst_n low, asynchronous): frame 0, first step pending, direction forward, registers to
// their defaults (clamp mode, step 1, no queued motion), both beat registers empty
`default_nettype none
`include "assert_macros.svh"
module animation_frame_sequencer import afs_pkg::*; #(
	parameter int FRAME_WIDTH = FRAME_WIDTH_DEF
) (
	input  var logic        clk,
	input  var logic        arst_n,
	// request stream
	input  var logic        s_axis_tvalid,
	output var logic        s_axis_tready,
	input  var logic [23:0] s_axis_tdata,  // new_frame[15:0], new_first, peek, zero pad
	input  var logic        s_axis_tuser,  // req_type
	// result stream
	output var logic        m_axis_tvalid,
	input  var logic        m_axis_tready,
	output var logic [31:0] m_axis_tdata,  // motion_kind[10:0], frame_out[16:0], range_error, zero pad
	// register writes
	input  var logic        cfg_valid,
	output var logic        cfg_ready,
	input  var logic [2:0]  cfg_index,
	input  var logic [16:0] cfg_data
);

	// register file
	cfg_t cfg_q;

	// sequencer state
	logic [FRAME_WIDTH-1:0] cur_frame_q;
	flags_t                 flags_q;

	// input stage
	logic valid_s1;
	req_t req_s1;
	logic adv_s1;

	// result stage
	logic    out_valid_q;
	result_t out_q;

	// step logic outputs
	result_t                res;
	logic [FRAME_WIDTH-1:0] cur_frame_nxt;
	flags_t                 flags_nxt;

	// registers are always writable; the user must write them only while idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.play_mode      <= MODE_CLAMP;
			cfg_q.last_frame     <= '0;
			cfg_q.frame_step     <= 16'sd1;
			cfg_q.jump_frame     <= '0;
			cfg_q.own_kind       <= '0;
			cfg_q.queued_kind    <= KIND_NONE;
			cfg_q.queued_trigger <= FRAME_NONE;
			cfg_q.queued_start   <= FRAME_NONE;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PLAY_MODE:      cfg_q.play_mode      <= cfg_data[2:0];
				REG_LAST_FRAME:     cfg_q.last_frame     <= cfg_data[15:0];
				REG_FRAME_STEP:     cfg_q.frame_step     <= $signed(cfg_data[15:0]);
				REG_JUMP_FRAME:     cfg_q.jump_frame     <= cfg_data[15:0];
				REG_OWN_KIND:       cfg_q.own_kind       <= $signed(cfg_data[10:0]);
				REG_QUEUED_KIND:    cfg_q.queued_kind    <= $signed(cfg_data[10:0]);
				REG_QUEUED_TRIGGER: cfg_q.queued_trigger <= $signed(cfg_data);
				REG_QUEUED_START:   cfg_q.queued_start   <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// input stage moves on when the result register is empty or being emptied
	assign adv_s1        = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			req_s1.req_type  <= s_axis_tuser;
			req_s1.new_frame <= s_axis_tdata[15:0];
			req_s1.new_first <= s_axis_tdata[16];
			req_s1.peek      <= s_axis_tdata[17];
		end
	end

	afs_step #(
		.FRAME_WIDTH(FRAME_WIDTH)
	) u_step (
		.cfg           (cfg_q),
		.req           (req_s1),
		.cur_frame     (cur_frame_q),
		.flags         (flags_q),
		.res           (res),
		.cur_frame_nxt (cur_frame_nxt),
		.flags_nxt     (flags_nxt)
	);

	// state commits together with the result, so the next request sees it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_frame_q           <= '0;
			flags_q.first_pending <= 1'b1;
			flags_q.step_backward <= 1'b0;
			out_valid_q           <= 1'b0;
		end else begin
			if (adv_s1) begin
				cur_frame_q <= cur_frame_nxt;
				flags_q     <= flags_nxt;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_q};

	// a range error beat carries no motion
	`AFS_ASSERT_IMP(a_err_no_motion, clk, arst_n, out_valid_q && out_q.range_error, out_q.motion_kind == '0 && out_q.frame_out == '0)
	// the current frame only moves on a set request
	`AFS_ASSERT_IMP(a_frame_on_set, clk, arst_n, !$stable(cur_frame_q), $past(adv_s1 && req_s1.req_type == REQ_SET))
	// direction only turns in ping-pong mode on a step
	`AFS_ASSERT_IMP(a_turn_pingpong, clk, arst_n, !$stable(flags_q.step_backward), $past(adv_s1 && req_s1.req_type == REQ_STEP && cfg_q.play_mode == MODE_PINGPONG))
	// a peek step never consumes the first-step flag
	`AFS_ASSERT_IMP(a_first_clear, clk, arst_n, $fell(flags_q.first_pending), $past(adv_s1 && (req_s1.req_type == REQ_SET || !req_s1.peek)))
	// a retired request always leaves a result beat behind
	`AFS_ASSERT_NXT(a_result_follows, clk, arst_n, adv_s1, out_valid_q)

endmodule
`default_nettype wire

>>> design/afs_step.sv
// next-frame and state update logic for one request
`default_nettype none
module afs_step import afs_pkg::*; #(
	parameter int FRAME_WIDTH = FRAME_WIDTH_DEF
) (
	input  var cfg_t                   cfg,
	input  var req_t                   req,
	input  var logic [FRAME_WIDTH-1:0] cur_frame,
	input  var flags_t                 flags,
	output var result_t                res,
	output var logic [FRAME_WIDTH-1:0] cur_frame_nxt,
	output var flags_t                 flags_nxt
);

	// wide enough for any frame plus a signed step
	localparam int NW = ((FRAME_WIDTH > 16) ? FRAME_WIDTH : 16) + 2;

	logic signed [NW-1:0] cur_ext;
	logic signed [NW-1:0] last_ext;
	logic signed [NW-1:0] step_ext;
	logic signed [NW-1:0] next;
	logic signed [NW-1:0] trig_ext;
	logic [31:0]          new_wide;
	logic                 queued;
	logic                 over;
	logic                 under;

	assign cur_ext  = $signed({{(NW-FRAME_WIDTH){1'b0}}, cur_frame});
	assign last_ext = $signed({{(NW-16){1'b0}}, cfg.last_frame});
	assign trig_ext = $signed({{(NW-17){cfg.queued_trigger[16]}}, cfg.queued_trigger});
	assign new_wide = {16'd0, req.new_frame};
	assign queued   = !cfg.queued_kind[10];

	always_comb begin
		step_ext = $signed({{(NW-16){cfg.frame_step[15]}}, cfg.frame_step});
		if (cfg.play_mode == MODE_PINGPONG && flags.step_backward) begin
			step_ext = -step_ext;
		end
	end

	assign next  = cur_ext + step_ext;
	assign over  = next > last_ext;
	assign under = next[NW-1];

	always_comb begin
		res           = '0;
		cur_frame_nxt = cur_frame;
		flags_nxt     = flags;
		if (req.req_type == REQ_SET) begin
			if (req.new_frame > cfg.last_frame) begin
				res.range_error = 1'b1;
			end else begin
				cur_frame_nxt           = new_wide[FRAME_WIDTH-1:0];
				flags_nxt.first_pending = req.new_first;
			end
		end else if (cfg.own_kind[10]) begin
			res.motion_kind = KIND_NONE;
		end else if (flags.first_pending) begin
			if (!req.peek) begin
				flags_nxt.first_pending = 1'b0;
			end
			res.motion_kind = cfg.own_kind;
			res.frame_out   = cur_ext[16:0];
		end else begin
			res.motion_kind = cfg.own_kind;
			case (cfg.play_mode) inside
				MODE_CLAMP, MODE_WRAP, MODE_PINGPONG, MODE_JUMP: begin
					if (over) begin
						if (queued) begin
							res.motion_kind = cfg.queued_kind;
							res.frame_out   = cfg.queued_start;
						end else if (cfg.play_mode == MODE_WRAP) begin
							res.frame_out = '0;
						end else if (cfg.play_mode == MODE_JUMP) begin
							res.frame_out = $signed({1'b0, cfg.jump_frame});
						end else begin
							res.frame_out = $signed({1'b0, cfg.last_frame});
						end
					end else if (under) begin
						if (cfg.play_mode == MODE_WRAP || cfg.play_mode == MODE_JUMP) begin
							res.frame_out = $signed({1'b0, cfg.last_frame});
						end else begin
							res.frame_out = '0;
						end
					end else if (queued && !cfg.queued_trigger[16] && next > trig_ext) begin
						res.motion_kind = cfg.queued_kind;
						res.frame_out   = cfg.queued_start;
					end else begin
						res.frame_out = next[16:0];
					end
					// ping-pong turns at either end
					if ((over || under) && cfg.play_mode == MODE_PINGPONG) begin
						flags_nxt.step_backward = !flags.step_backward;
					end
				end
				default: begin
					res.frame_out = cur_ext[16:0];
				end
			endcase
		end
	end

endmodule
`default_nettype wire
